FILE: rtl/core/ftcs_pkg.sv
// ----------------------------------------------------------------------------
// ftcs_pkg: shared types and constants of the advection-dispersion stencil
// Configuration register indexes, cell classification flags, coefficient
// bundle, back-end states and saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package ftcs_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgColsW = 9;
  localparam int unsigned CfgRowsW = 11;
  localparam int unsigned RowOutW  = 10;
  localparam int unsigned ColOutW  = 8;
  localparam int unsigned MinExtent  = 3;
  localparam int unsigned QueueDepth = 2;

  // Wide intermediate width for saturating sums
  localparam int unsigned SatW = 70;
  localparam logic signed [SatW-1:0] SatMax = 70'sd2147483647;
  localparam logic signed [SatW-1:0] SatMin = -70'sd2147483648;

  typedef enum logic [CfgIdxW-1:0] {
    CfgColumns  = 3'd0,
    CfgRows     = 3'd1,
    CfgInvDy    = 3'd2,
    CfgInvDySq  = 3'd3,
    CfgInvDxSq  = 3'd4,
    CfgTimeStep = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [DataW-1:0] inv_dy;
    logic [DataW-1:0] inv_dy_sq;
    logic [DataW-1:0] inv_dx_sq;
    logic [DataW-1:0] time_step;
  } coef_t;

  typedef struct packed {
    logic last_col;   // column closes the row
    logic final_row;  // row closes the grid
    logic has_above;  // row index at least one
    logic deep_row;   // row index at least two
    logic col_nz;     // column index at least one
    logic col_one;    // column index exactly one
    logic edge_prep;  // column feeds the right edge copy
  } cell_flags_t;

  typedef struct packed {
    logic clearing;
  } bk_status_t;

  typedef enum logic [4:0] {
    BkClear, BkIdle, BkRead, BkRead2, BkWin,
    BkDyH, BkDyL, BkYyH, BkYyL, BkXxH, BkXxL,
    BkAdv, BkLap, BkDsp, BkDcdt, BkTsH, BkTsL, BkFin,
    BkEmit
  } bk_state_e;

  typedef enum logic [1:0] {
    SlotAboveEdge = 2'd0,
    SlotAbove     = 2'd1,
    SlotFinalEdge = 2'd2,
    SlotFinal     = 2'd3
  } emit_slot_e;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [SatW-1:0] x);
    logic signed [DataW-1:0] r;
    if (x > SatMax) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < SatMin) begin
      r = 32'sh8000_0000;
    end else begin
      r = signed'(x[DataW-1:0]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ftcs_queue.sv
// ----------------------------------------------------------------------------
// ftcs_queue: short first-in first-out queue between front and back
// Holds classified cells so that either side may stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module ftcs_queue #(
  parameter int unsigned W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  input  wire logic         pop_i,
  output logic      [W-1:0] data_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam int unsigned PtrW = $clog2(ftcs_pkg::QueueDepth);
  localparam int unsigned CntW = PtrW + 1;

  logic [W-1:0]    entry_q [ftcs_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(ftcs_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(ftcs_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(ftcs_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ftcs_front.sv
// ----------------------------------------------------------------------------
// ftcs_front: input side of the stencil
// Holds the configuration registers, counts rows and columns and tags each
// accepted cell with its position flags before queueing it.
// ----------------------------------------------------------------------------
`default_nettype none

module ftcs_front #(
  parameter int unsigned MAX_COLUMNS = 256,
  parameter int unsigned MAX_ROWS    = 1024,
  localparam int unsigned CW = $clog2(MAX_COLUMNS),
  localparam int unsigned RW = $clog2(MAX_ROWS)
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [ftcs_pkg::DataW-1:0]   conc_in_i,
  input  wire logic signed [ftcs_pkg::DataW-1:0]   velocity_in_i,
  input  wire logic signed [ftcs_pkg::DataW-1:0]   dispersion_in_i,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [ftcs_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [ftcs_pkg::DataW-1:0]          cfg_data_i,
  input  wire logic                                q_full_i,
  input  wire ftcs_pkg::bk_status_t                status_i,
  output logic                                     push_o,
  output logic [CW-1:0]                            cell_col_o,
  output logic [RW-1:0]                            cell_row_o,
  output ftcs_pkg::cell_flags_t                    cell_flags_o,
  output ftcs_pkg::coef_t                          coef_o
);

  logic [ftcs_pkg::CfgColsW-1:0] cols_cfg_q;
  logic [ftcs_pkg::CfgRowsW-1:0] rows_cfg_q;
  ftcs_pkg::coef_t               coef_q;
  logic [CW-1:0]                 col_q;
  logic [RW-1:0]                 row_q;
  logic [CW:0]                   cols_lim;
  logic [RW:0]                   rows_lim;
  ftcs_pkg::cell_flags_t         flags;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full_i | status_i.clearing;
  assign push_o      = in_valid_i & ~in_stall_o;
  assign coef_o      = coef_q;

  // Clamp the configured extents to [MinExtent, MAX]
  always_comb begin
    if (32'(cols_cfg_q) < 32'(ftcs_pkg::MinExtent)) begin
      cols_lim = (CW+1)'(ftcs_pkg::MinExtent);
    end else if (32'(cols_cfg_q) > 32'(MAX_COLUMNS)) begin
      cols_lim = (CW+1)'(MAX_COLUMNS);
    end else begin
      cols_lim = (CW+1)'(cols_cfg_q);
    end
    if (32'(rows_cfg_q) < 32'(ftcs_pkg::MinExtent)) begin
      rows_lim = (RW+1)'(ftcs_pkg::MinExtent);
    end else if (32'(rows_cfg_q) > 32'(MAX_ROWS)) begin
      rows_lim = (RW+1)'(MAX_ROWS);
    end else begin
      rows_lim = (RW+1)'(rows_cfg_q);
    end
  end

  always_comb begin
    flags.last_col  = {1'b0, col_q} >= cols_lim - (CW+1)'(1);
    flags.final_row = {1'b0, row_q} >= rows_lim - (RW+1)'(1);
    flags.has_above = (row_q != '0);
    flags.deep_row  = (row_q > RW'(1));
    flags.col_nz    = (col_q != '0);
    flags.col_one   = (col_q == CW'(1));
    flags.edge_prep = ({1'b0, col_q} == cols_lim - (CW+1)'(2));
  end

  assign cell_col_o   = col_q;
  assign cell_row_o   = row_q;
  assign cell_flags_o = flags;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_cfg_q       <= ftcs_pkg::CfgColsW'(256);
      rows_cfg_q       <= ftcs_pkg::CfgRowsW'(1024);
      coef_q.inv_dy    <= 32'h0001_0000;
      coef_q.inv_dy_sq <= 32'h0001_0000;
      coef_q.inv_dx_sq <= 32'h0001_0000;
      coef_q.time_step <= 32'h0001_0000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ftcs_pkg::CfgColumns:  cols_cfg_q       <= cfg_data_i[ftcs_pkg::CfgColsW-1:0];
        ftcs_pkg::CfgRows:     rows_cfg_q       <= cfg_data_i[ftcs_pkg::CfgRowsW-1:0];
        ftcs_pkg::CfgInvDy:    coef_q.inv_dy    <= cfg_data_i;
        ftcs_pkg::CfgInvDySq:  coef_q.inv_dy_sq <= cfg_data_i;
        ftcs_pkg::CfgInvDxSq:  coef_q.inv_dx_sq <= cfg_data_i;
        ftcs_pkg::CfgTimeStep: coef_q.time_step <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the raster position on every accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (push_o) begin
      if (flags.last_col) begin
        col_q <= '0;
        row_q <= flags.final_row ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ftcs_back.sv
// ----------------------------------------------------------------------------
// ftcs_back: execution side of the stencil
// Owns the line buffers, runs the update through one shared multiplier and
// emits up to four result words per cell through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ftcs_back #(
  parameter int unsigned MAX_COLUMNS = 256,
  parameter int unsigned MAX_ROWS    = 1024,
  localparam int unsigned CW = $clog2(MAX_COLUMNS),
  localparam int unsigned RW = $clog2(MAX_ROWS)
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                q_empty_i,
  output logic                                     pop_o,
  input  wire logic signed [ftcs_pkg::DataW-1:0]   cell_conc_i,
  input  wire logic signed [ftcs_pkg::DataW-1:0]   cell_vel_i,
  input  wire logic signed [ftcs_pkg::DataW-1:0]   cell_disp_i,
  input  wire logic [CW-1:0]                       cell_col_i,
  input  wire logic [RW-1:0]                       cell_row_i,
  input  wire ftcs_pkg::cell_flags_t               cell_flags_i,
  input  wire ftcs_pkg::coef_t                     coef_i,
  output ftcs_pkg::bk_status_t                     status_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [ftcs_pkg::DataW-1:0]        conc_out_o,
  output logic [ftcs_pkg::RowOutW-1:0]             row_out_o,
  output logic [ftcs_pkg::ColOutW-1:0]             column_out_o,
  output logic                                     grid_done_o
);

  localparam int unsigned MulAW = 35;
  localparam int unsigned MulBW = 33;
  localparam int unsigned ProdW = MulAW + MulBW;
  localparam int unsigned AdvW  = 48;

  ftcs_pkg::bk_state_e  state_q, state_d;
  ftcs_pkg::emit_slot_e pos_q;
  logic [CW-1:0]        clr_q;

  // Current cell
  logic signed [31:0]    cmd_c_q, cmd_v_q, cmd_d_q;
  logic [CW-1:0]         cmd_col_q;
  logic [RW-1:0]         cmd_row_q;
  ftcs_pkg::cell_flags_t cmd_flags_q;

  // Stencil window and working registers
  logic signed [31:0] c_up_q, c_mid_q, c_left_q, c_prev_q, v_up_q, v_mid_q, d_mid_q;
  logic signed [32:0] diff1_q;
  logic signed [33:0] diff2_q, diff3_q;
  logic signed [31:0] dcdy_q, dyy_q, dxx_q, lap_q, dcdt_q, val_q, held_q;
  logic signed [AdvW-1:0]  adv_q;
  logic signed [ProdW-1:0] prod_q, hi_q;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic                    mul_en;
  logic signed [31:0]      fin;

  // Line buffer ports
  logic               cur;
  logic [CW-1:0]      col_next, wr_addr;
  logic [1:0]         wr_en;
  logic [1:0][CW-1:0] conc_rd_addr;
  logic [1:0][31:0]   conc_rd_q, vel_rd_q;
  logic [31:0]        disp_rd_q;
  logic [31:0]        wr_conc, wr_vel, wr_disp;
  logic               clearing;

  // Output register
  logic               out_valid_q, out_done_q;
  logic signed [31:0] out_conc_q;
  logic [RW-1:0]      out_row_q;
  logic [CW-1:0]      out_col_q;

  logic               em_en, em_done, out_free, load_out, advance, interior;
  logic signed [31:0] em_conc;
  logic [RW-1:0]      em_row;
  logic [CW-1:0]      em_col;
  logic               above, final_emit;

  assign clearing          = (state_q == ftcs_pkg::BkClear);
  assign status_o.clearing = clearing;
  assign cur               = cmd_row_q[0];
  assign col_next          = (cmd_col_q == CW'(MAX_COLUMNS - 1)) ? '0 : cmd_col_q + CW'(1);
  assign wr_addr           = clearing ? clr_q : cmd_col_q;
  assign wr_conc           = clearing ? '0 : cmd_c_q;
  assign wr_vel            = clearing ? '0 : cmd_v_q;
  assign wr_disp           = clearing ? '0 : cmd_d_q;

  for (genvar b = 0; b < 2; b++) begin : g_bank
    logic [31:0] conc_mem [MAX_COLUMNS];
    logic [31:0] vel_mem  [MAX_COLUMNS];

    assign wr_en[b] = clearing | ((state_q == ftcs_pkg::BkWin) && (cur == 1'(b)));
    // The previous-row bank also fetches the right neighbour
    assign conc_rd_addr[b] = ((cur != 1'(b)) && (state_q == ftcs_pkg::BkRead2)) ?
                             col_next : cmd_col_q;

    always_ff @(posedge clk_i) begin
      if (wr_en[b]) begin
        conc_mem[wr_addr] <= wr_conc;
        vel_mem[wr_addr]  <= wr_vel;
      end
      conc_rd_q[b] <= conc_mem[conc_rd_addr[b]];
      vel_rd_q[b]  <= vel_mem[cmd_col_q];
    end
  end

  logic [31:0] disp_mem [MAX_COLUMNS];

  always_ff @(posedge clk_i) begin
    if (clearing || (state_q == ftcs_pkg::BkWin)) begin
      disp_mem[wr_addr] <= wr_disp;
    end
    disp_rd_q <= disp_mem[cmd_col_q];
  end

  assign interior = cmd_flags_q.has_above & cmd_flags_q.col_nz & ~cmd_flags_q.last_col &
                    cmd_flags_q.deep_row & (v_up_q > 32'sd0);

  // Shared multiplier operand selection
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      ftcs_pkg::BkDyH: begin
        mul_a = MulAW'(diff1_q);
        mul_b = $signed({17'b0, coef_i.inv_dy[31:16]});
      end
      ftcs_pkg::BkDyL: begin
        mul_a = MulAW'(diff1_q);
        mul_b = $signed({17'b0, coef_i.inv_dy[15:0]});
      end
      ftcs_pkg::BkYyH: begin
        mul_a = MulAW'(diff2_q);
        mul_b = $signed({17'b0, coef_i.inv_dy_sq[31:16]});
      end
      ftcs_pkg::BkYyL: begin
        mul_a = MulAW'(diff2_q);
        mul_b = $signed({17'b0, coef_i.inv_dy_sq[15:0]});
      end
      ftcs_pkg::BkXxH: begin
        mul_a = MulAW'(diff3_q);
        mul_b = $signed({17'b0, coef_i.inv_dx_sq[31:16]});
      end
      ftcs_pkg::BkXxL: begin
        mul_a = MulAW'(diff3_q);
        mul_b = $signed({17'b0, coef_i.inv_dx_sq[15:0]});
      end
      ftcs_pkg::BkAdv: begin
        mul_a = MulAW'(v_mid_q);
        mul_b = MulBW'(dcdy_q);
      end
      ftcs_pkg::BkDsp: begin
        mul_a = MulAW'(d_mid_q);
        mul_b = MulBW'(lap_q);
      end
      ftcs_pkg::BkTsH: begin
        mul_a = MulAW'(dcdt_q);
        mul_b = $signed({17'b0, coef_i.time_step[31:16]});
      end
      ftcs_pkg::BkTsL: begin
        mul_a = MulAW'(dcdt_q);
        mul_b = $signed({17'b0, coef_i.time_step[15:0]});
      end
      default: mul_en = 1'b0;
    endcase
  end

  // Close a split product: high half plus floored low half, saturated
  assign fin = ftcs_pkg::sat32(ftcs_pkg::SatW'(hi_q) + ftcs_pkg::SatW'(prod_q >>> 16));

  // Emission slots of one cell
  assign above      = cmd_flags_q.has_above & cmd_flags_q.col_nz;
  assign final_emit = cmd_flags_q.final_row & cmd_flags_q.col_nz;

  always_comb begin
    em_en   = 1'b0;
    em_conc = val_q;
    em_row  = cmd_row_q - RW'(1);
    em_col  = cmd_col_q;
    em_done = 1'b0;
    case (pos_q)
      ftcs_pkg::SlotAboveEdge: begin
        em_en  = above & ~cmd_flags_q.last_col & cmd_flags_q.col_one;
        em_col = '0;
      end
      ftcs_pkg::SlotAbove: begin
        em_en   = above;
        em_conc = cmd_flags_q.last_col ? held_q : val_q;
      end
      ftcs_pkg::SlotFinalEdge: begin
        em_en   = final_emit & ~cmd_flags_q.last_col & cmd_flags_q.col_one;
        em_conc = cmd_c_q;
        em_row  = cmd_row_q;
        em_col  = '0;
      end
      ftcs_pkg::SlotFinal: begin
        em_en   = final_emit;
        em_conc = cmd_flags_q.last_col ? c_prev_q : cmd_c_q;
        em_row  = cmd_row_q;
        em_done = cmd_flags_q.last_col & cmd_flags_q.final_row;
      end
      default: ;
    endcase
  end

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign load_out = (state_q == ftcs_pkg::BkEmit) & em_en & out_free;
  assign advance  = (state_q == ftcs_pkg::BkEmit) & (~em_en | out_free);

  // Next state
  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      ftcs_pkg::BkClear: if (clr_q == CW'(MAX_COLUMNS - 1)) state_d = ftcs_pkg::BkIdle;
      ftcs_pkg::BkIdle: begin
        if (!q_empty_i) begin
          pop_o   = 1'b1;
          state_d = ftcs_pkg::BkRead;
        end
      end
      ftcs_pkg::BkRead:  state_d = ftcs_pkg::BkRead2;
      ftcs_pkg::BkRead2: state_d = ftcs_pkg::BkWin;
      ftcs_pkg::BkWin:   state_d = interior ? ftcs_pkg::BkDyH : ftcs_pkg::BkEmit;
      ftcs_pkg::BkDyH:   state_d = ftcs_pkg::BkDyL;
      ftcs_pkg::BkDyL:   state_d = ftcs_pkg::BkYyH;
      ftcs_pkg::BkYyH:   state_d = ftcs_pkg::BkYyL;
      ftcs_pkg::BkYyL:   state_d = ftcs_pkg::BkXxH;
      ftcs_pkg::BkXxH:   state_d = ftcs_pkg::BkXxL;
      ftcs_pkg::BkXxL:   state_d = ftcs_pkg::BkAdv;
      ftcs_pkg::BkAdv:   state_d = ftcs_pkg::BkLap;
      ftcs_pkg::BkLap:   state_d = ftcs_pkg::BkDsp;
      ftcs_pkg::BkDsp:   state_d = ftcs_pkg::BkDcdt;
      ftcs_pkg::BkDcdt:  state_d = ftcs_pkg::BkTsH;
      ftcs_pkg::BkTsH:   state_d = ftcs_pkg::BkTsL;
      ftcs_pkg::BkTsL:   state_d = ftcs_pkg::BkFin;
      ftcs_pkg::BkFin:   state_d = ftcs_pkg::BkEmit;
      ftcs_pkg::BkEmit: begin
        if (advance && (pos_q == ftcs_pkg::SlotFinal)) state_d = ftcs_pkg::BkIdle;
      end
      default: state_d = ftcs_pkg::BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ftcs_pkg::BkClear;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      pos_q       <= ftcs_pkg::SlotAboveEdge;
      out_valid_q <= 1'b0;
      held_q      <= '0;
    end else begin
      if (clearing) begin
        clr_q <= clr_q + CW'(1);
      end
      if (advance) begin
        pos_q <= ftcs_pkg::emit_slot_e'(pos_q + 2'd1);
        if ((pos_q == ftcs_pkg::SlotFinal) && above && !cmd_flags_q.last_col &&
            cmd_flags_q.edge_prep) begin
          held_q <= val_q;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_c_q     <= cell_conc_i;
      cmd_v_q     <= cell_vel_i;
      cmd_d_q     <= cell_disp_i;
      cmd_col_q   <= cell_col_i;
      cmd_row_q   <= cell_row_i;
      cmd_flags_q <= cell_flags_i;
      // Shift the window: last cell's centre becomes the left neighbour
      c_prev_q    <= cmd_c_q;
      c_left_q    <= c_mid_q;
    end
    if (state_q == ftcs_pkg::BkRead2) begin
      c_up_q  <= signed'(cur ? conc_rd_q[1] : conc_rd_q[0]);
      c_mid_q <= signed'(cur ? conc_rd_q[0] : conc_rd_q[1]);
      v_up_q  <= signed'(cur ? vel_rd_q[1] : vel_rd_q[0]);
      v_mid_q <= signed'(cur ? vel_rd_q[0] : vel_rd_q[1]);
      d_mid_q <= signed'(disp_rd_q);
    end
    if (state_q == ftcs_pkg::BkWin) begin
      diff1_q <= 33'(c_mid_q) - 33'(c_up_q);
      diff2_q <= 34'(cmd_c_q) - (34'(c_mid_q) <<< 1) + 34'(c_up_q);
      diff3_q <= 34'(signed'(cur ? conc_rd_q[0] : conc_rd_q[1])) - (34'(c_mid_q) <<< 1) +
                 34'(c_left_q);
      val_q   <= c_mid_q;
    end
    if (mul_en) begin
      prod_q <= ProdW'(mul_a) * ProdW'(mul_b);
    end
    case (state_q)
      ftcs_pkg::BkDyL, ftcs_pkg::BkYyL, ftcs_pkg::BkXxL, ftcs_pkg::BkTsL: hi_q <= prod_q;
      ftcs_pkg::BkYyH: dcdy_q <= fin;
      ftcs_pkg::BkXxH: dyy_q  <= fin;
      ftcs_pkg::BkAdv: dxx_q  <= fin;
      ftcs_pkg::BkLap: begin
        adv_q <= AdvW'(prod_q >>> 16);
        lap_q <= ftcs_pkg::sat32(ftcs_pkg::SatW'(dxx_q) + ftcs_pkg::SatW'(dyy_q));
      end
      ftcs_pkg::BkDcdt: begin
        dcdt_q <= ftcs_pkg::sat32(ftcs_pkg::SatW'(prod_q >>> 16) - ftcs_pkg::SatW'(adv_q));
      end
      ftcs_pkg::BkFin: val_q <= ftcs_pkg::sat32(ftcs_pkg::SatW'(c_mid_q) + ftcs_pkg::SatW'(fin));
      default: ;
    endcase
    if (load_out) begin
      out_conc_q <= em_conc;
      out_row_q  <= em_row;
      out_col_q  <= em_col;
      out_done_q <= em_done;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign conc_out_o   = out_conc_q;
  assign row_out_o    = ftcs_pkg::RowOutW'(out_row_q);
  assign column_out_o = ftcs_pkg::ColOutW'(out_col_q);
  assign grid_done_o  = out_done_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == ftcs_pkg::BkIdle) && !q_empty_i)
    else $error("queue popped outside idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !out_valid_q)
    else $error("result word during clearing pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ftcs_pkg::BkEmit) |-> (pos_q == ftcs_pkg::SlotAboveEdge))
    else $error("emission slot not rewound");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ftcs_pkg::BkWin) |=> (state_q != ftcs_pkg::BkWin))
    else $error("line buffer written twice for one cell");

endmodule

`default_nettype wire

FILE: rtl/core/ftcs_advection_dispersion_stencil.sv
// Flow: a pass-through cell is read from the line buffers, windowed and sent
//   to the output register after any left edge copy; an updated interior
//   cell first runs its products and time step on the shared multiplier.
// The back end takes a new cell only once the last one is emitted, bounded
//   by the single shared multiplier and the one read port of each row bank.
// Reset: a clearing pass zeroes all MAX_COLUMNS line buffer entries;
//   in_stall_o stays high until it ends, configuration writes are taken.
// ----------------------------------------------------------------------------
// ftcs_advection_dispersion_stencil: streaming explicit advection-dispersion
// Takes grid cells in raster order and emits forward-time updates, upwind in
// advection and centred in dispersion, with edge columns copying neighbours.
// ----------------------------------------------------------------------------
`default_nettype none

module ftcs_advection_dispersion_stencil #(
  parameter int unsigned MAX_COLUMNS = 256,
  parameter int unsigned MAX_ROWS    = 1024
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // cell words in
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [ftcs_pkg::DataW-1:0] conc_in_i,
  input  wire logic signed [ftcs_pkg::DataW-1:0] velocity_in_i,
  input  wire logic signed [ftcs_pkg::DataW-1:0] dispersion_in_i,
  // result words out
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [ftcs_pkg::DataW-1:0]      conc_out_o,
  output logic [ftcs_pkg::RowOutW-1:0]           row_out_o,
  output logic [ftcs_pkg::ColOutW-1:0]           column_out_o,
  output logic                                   grid_done_o,
  // configuration writes
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [ftcs_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [ftcs_pkg::DataW-1:0]        cfg_data_i
);

  localparam int unsigned CW   = $clog2(MAX_COLUMNS);
  localparam int unsigned RW   = $clog2(MAX_ROWS);
  localparam int unsigned FlgW = $bits(ftcs_pkg::cell_flags_t);
  localparam int unsigned QW   = FlgW + RW + CW + 3 * ftcs_pkg::DataW;

  // Front side: position tags for each accepted word
  logic                  push, q_full, q_empty, pop;
  logic [CW-1:0]         f_col, b_col;
  logic [RW-1:0]         f_row, b_row;
  ftcs_pkg::cell_flags_t f_flags, b_flags;
  ftcs_pkg::coef_t       coef;
  ftcs_pkg::bk_status_t  bk_status;
  logic [QW-1:0]         q_wdata, q_rdata;
  logic signed [ftcs_pkg::DataW-1:0] b_conc, b_vel, b_disp;

  ftcs_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .conc_in_i       (conc_in_i),
    .velocity_in_i   (velocity_in_i),
    .dispersion_in_i (dispersion_in_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .q_full_i        (q_full),
    .status_i        (bk_status),
    .push_o          (push),
    .cell_col_o      (f_col),
    .cell_row_o      (f_row),
    .cell_flags_o    (f_flags),
    .coef_o          (coef)
  );

  // Pack the tagged word; the queue lets the back end stall on its own
  assign q_wdata = {f_flags, f_row, f_col, conc_in_i, velocity_in_i, dispersion_in_i};

  ftcs_queue #(
    .W (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_wdata),
    .pop_i   (pop),
    .data_o  (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign {b_flags, b_row, b_col, b_conc, b_vel, b_disp} = q_rdata;

  // Back side: line buffers, update arithmetic and result emission
  ftcs_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .pop_o        (pop),
    .cell_conc_i  (b_conc),
    .cell_vel_i   (b_vel),
    .cell_disp_i  (b_disp),
    .cell_col_i   (b_col),
    .cell_row_i   (b_row),
    .cell_flags_i (b_flags),
    .coef_i       (coef),
    .status_o     (bk_status),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .conc_out_o   (conc_out_o),
    .row_out_o    (row_out_o),
    .column_out_o (column_out_o),
    .grid_done_o  (grid_done_o)
  );

endmodule

`default_nettype wire
